// ===== hw/rtl/jsv_pkg.sv =====
// Shared parser mode codes, control types and character-class helpers for the JSON validator.
package jsv_pkg;

    localparam int MODE_W = 5;
    localparam int HEX_W  = 3;

    // Parser modes.
    localparam logic [MODE_W-1:0] PM_TOP       = 5'd0;
    localparam logic [MODE_W-1:0] PM_OBJ_FIRST = 5'd1;
    localparam logic [MODE_W-1:0] PM_OBJ_KEY   = 5'd2;
    localparam logic [MODE_W-1:0] PM_COLON     = 5'd3;
    localparam logic [MODE_W-1:0] PM_VALUE     = 5'd4;
    localparam logic [MODE_W-1:0] PM_ARR_FIRST = 5'd5;
    localparam logic [MODE_W-1:0] PM_AFTER     = 5'd6;
    localparam logic [MODE_W-1:0] PM_DONE      = 5'd7;
    localparam logic [MODE_W-1:0] PM_STR       = 5'd8;
    localparam logic [MODE_W-1:0] PM_ESC       = 5'd9;
    localparam logic [MODE_W-1:0] PM_HEX       = 5'd10;
    localparam logic [MODE_W-1:0] PM_KSTR      = 5'd11;
    localparam logic [MODE_W-1:0] PM_KESC      = 5'd12;
    localparam logic [MODE_W-1:0] PM_KHEX      = 5'd13;
    localparam logic [MODE_W-1:0] PM_N_SIGN    = 5'd14;
    localparam logic [MODE_W-1:0] PM_N_ZERO    = 5'd15;
    localparam logic [MODE_W-1:0] PM_N_INT     = 5'd16;
    localparam logic [MODE_W-1:0] PM_N_DOT     = 5'd17;
    localparam logic [MODE_W-1:0] PM_N_FRAC    = 5'd18;
    localparam logic [MODE_W-1:0] PM_N_EXP     = 5'd19;
    localparam logic [MODE_W-1:0] PM_N_ESIGN   = 5'd20;
    localparam logic [MODE_W-1:0] PM_N_EDIG    = 5'd21;
    localparam logic [MODE_W-1:0] PM_LIT_T     = 5'd22;
    localparam logic [MODE_W-1:0] PM_LIT_F     = 5'd23;
    localparam logic [MODE_W-1:0] PM_LIT_N     = 5'd24;

    // Bytes below this value are control characters and are illegal inside strings.
    localparam logic [7:0] CTRL_LIMIT = 8'h20;
    localparam logic [HEX_W-1:0] HEX_DIGITS = 3'd4;

    // Per-byte parser control state, excluding the nesting depth.
    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [HEX_W-1:0]  hex_left;
        logic              err;
        logic              done;
    } t_ctl;

    // Container stack update requested for one byte.
    typedef struct packed {
        logic push;
        logic pop;
        logic kind;   // 1 = array, 0 = object
    } t_stack_op;

    function automatic logic is_ws(input logic [7:0] c);
        return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= "0") && (c <= "9");
    endfunction

    function automatic logic is_hex(input logic [7:0] c);
        return is_digit(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
    endfunction

    function automatic logic is_escape(input logic [7:0] c);
        return (c == "\"") || (c == "\\") || (c == "/") || (c == "b") || (c == "f") ||
               (c == "n") || (c == "r") || (c == "t");
    endfunction

    // Length of the literal word belonging to a literal mode.
    function automatic logic [HEX_W-1:0] lit_len(input logic [MODE_W-1:0] mode);
        return (mode == PM_LIT_F) ? 3'd5 : 3'd4;
    endfunction

    // Expected letter at a position of the literal word.
    function automatic logic [7:0] lit_char(input logic [MODE_W-1:0] mode,
                                            input logic [HEX_W-1:0] idx);
        logic [7:0] ch;
        ch = 8'h00;
        if (mode == PM_LIT_T) begin
            unique case (idx)
                3'd0:    ch = "t";
                3'd1:    ch = "r";
                3'd2:    ch = "u";
                3'd3:    ch = "e";
                default: ch = 8'h00;
            endcase
        end else if (mode == PM_LIT_F) begin
            unique case (idx)
                3'd0:    ch = "f";
                3'd1:    ch = "a";
                3'd2:    ch = "l";
                3'd3:    ch = "s";
                3'd4:    ch = "e";
                default: ch = 8'h00;
            endcase
        end else begin
            unique case (idx)
                3'd0:    ch = "n";
                3'd1:    ch = "u";
                3'd2:    ch = "l";
                3'd3:    ch = "l";
                default: ch = 8'h00;
            endcase
        end
        return ch;
    endfunction

endpackage

// ===== hw/rtl/jsv_step.sv =====
// Combinational next-state logic of the JSON parser for one input byte.
module jsv_step #(
    parameter int MAX_NEST = 32,
    parameter int DEPTH_W  = $clog2(MAX_NEST + 2)
) (
    input  jsv_pkg::t_ctl      i_ctl,
    input  logic [DEPTH_W-1:0] i_depth,
    input  logic               i_top_kind,
    input  logic [7:0]         i_byte,
    output jsv_pkg::t_ctl      o_ctl,
    output logic [DEPTH_W-1:0] o_depth,
    output jsv_pkg::t_stack_op o_op
);
    import jsv_pkg::*;

    logic [7:0]       c;
    logic             ws;
    logic             too_deep;
    logic             req_start;
    logic             req_after;
    logic             req_push;
    logic             req_pop;
    logic             push_kind;
    logic [HEX_W-1:0] h;

    assign c        = i_byte;
    assign ws       = is_ws(i_byte);
    assign too_deep = i_depth > DEPTH_W'(MAX_NEST);

    always_comb begin
        o_ctl     = i_ctl;
        o_depth   = i_depth;
        o_op      = '0;
        req_start = 1'b0;
        req_after = 1'b0;
        req_push  = 1'b0;
        req_pop   = 1'b0;
        push_kind = 1'b0;
        h         = '0;

        if (!i_ctl.done && !i_ctl.err) begin
            if (c == 8'h00) begin
                o_ctl.done = 1'b1;
            end else begin
                unique case (i_ctl.mode)
                    PM_TOP: begin
                        if (!ws) begin
                            if (c == "{") req_push = 1'b1;
                            else o_ctl.err = 1'b1;
                        end
                    end
                    PM_OBJ_FIRST: begin
                        if (!ws) begin
                            if (c == "}") req_pop = 1'b1;
                            else if (c == "\"") o_ctl.mode = PM_KSTR;
                            else o_ctl.err = 1'b1;
                        end
                    end
                    PM_OBJ_KEY: begin
                        if (!ws) begin
                            if (c == "\"") o_ctl.mode = PM_KSTR;
                            else o_ctl.err = 1'b1;
                        end
                    end
                    PM_COLON: begin
                        if (!ws) begin
                            if (c == ":") o_ctl.mode = PM_VALUE;
                            else o_ctl.err = 1'b1;
                        end
                    end
                    PM_VALUE: begin
                        if (!ws) req_start = 1'b1;
                    end
                    PM_ARR_FIRST: begin
                        if (!ws) begin
                            if (c == "]") req_pop = 1'b1;
                            else req_start = 1'b1;
                        end
                    end
                    PM_AFTER: req_after = 1'b1;
                    PM_DONE: begin
                        if (!ws) o_ctl.err = 1'b1;
                    end
                    PM_STR, PM_KSTR: begin
                        if (c == "\"") o_ctl.mode = (i_ctl.mode == PM_KSTR) ? PM_COLON : PM_AFTER;
                        else if (c < CTRL_LIMIT) o_ctl.err = 1'b1;
                        else if (c == "\\") o_ctl.mode = (i_ctl.mode == PM_KSTR) ? PM_KESC : PM_ESC;
                    end
                    PM_ESC, PM_KESC: begin
                        if (is_escape(c)) begin
                            o_ctl.mode = (i_ctl.mode == PM_KESC) ? PM_KSTR : PM_STR;
                        end else if (c == "u") begin
                            o_ctl.mode     = (i_ctl.mode == PM_KESC) ? PM_KHEX : PM_HEX;
                            o_ctl.hex_left = HEX_DIGITS;
                        end else begin
                            o_ctl.err = 1'b1;
                        end
                    end
                    PM_HEX, PM_KHEX: begin
                        if (!is_hex(c)) begin
                            o_ctl.err = 1'b1;
                        end else begin
                            h              = i_ctl.hex_left - 3'd1;
                            o_ctl.hex_left = h;
                            if (h == '0) o_ctl.mode = (i_ctl.mode == PM_KHEX) ? PM_KSTR : PM_STR;
                        end
                    end
                    PM_N_SIGN: begin
                        if (c == "0") o_ctl.mode = PM_N_ZERO;
                        else if (c >= "1" && c <= "9") o_ctl.mode = PM_N_INT;
                        else o_ctl.err = 1'b1;
                    end
                    PM_N_ZERO, PM_N_INT: begin
                        if (i_ctl.mode == PM_N_INT && is_digit(c)) begin
                            o_ctl.mode = PM_N_INT;
                        end else if (c == ".") begin
                            o_ctl.mode = PM_N_DOT;
                        end else if (c == "e" || c == "E") begin
                            o_ctl.mode = PM_N_EXP;
                        end else begin
                            o_ctl.mode = PM_AFTER;
                            req_after  = 1'b1;
                        end
                    end
                    PM_N_DOT: begin
                        if (is_digit(c)) o_ctl.mode = PM_N_FRAC;
                        else o_ctl.err = 1'b1;
                    end
                    PM_N_FRAC: begin
                        if (is_digit(c)) begin
                            o_ctl.mode = PM_N_FRAC;
                        end else if (c == "e" || c == "E") begin
                            o_ctl.mode = PM_N_EXP;
                        end else begin
                            o_ctl.mode = PM_AFTER;
                            req_after  = 1'b1;
                        end
                    end
                    PM_N_EXP: begin
                        if (c == "+" || c == "-") o_ctl.mode = PM_N_ESIGN;
                        else if (is_digit(c)) o_ctl.mode = PM_N_EDIG;
                        else o_ctl.err = 1'b1;
                    end
                    PM_N_ESIGN: begin
                        if (is_digit(c)) o_ctl.mode = PM_N_EDIG;
                        else o_ctl.err = 1'b1;
                    end
                    PM_N_EDIG: begin
                        if (!is_digit(c)) begin
                            o_ctl.mode = PM_AFTER;
                            req_after  = 1'b1;
                        end
                    end
                    PM_LIT_T, PM_LIT_F, PM_LIT_N: begin
                        if (i_ctl.hex_left >= lit_len(i_ctl.mode) ||
                            c != lit_char(i_ctl.mode, i_ctl.hex_left)) begin
                            o_ctl.err = 1'b1;
                        end else begin
                            h = i_ctl.hex_left + 3'd1;
                            if (h == lit_len(i_ctl.mode)) begin
                                o_ctl.hex_left = '0;
                                o_ctl.mode     = PM_AFTER;
                            end else begin
                                o_ctl.hex_left = h;
                            end
                        end
                    end
                    default: o_ctl.err = 1'b1;
                endcase
            end
        end

        // A value may begin here; the nesting limit applies to scalars too.
        if (req_start) begin
            if (too_deep) begin
                o_ctl.err = 1'b1;
            end else if (c == "\"") begin
                o_ctl.mode = PM_STR;
            end else if (c == "{") begin
                req_push  = 1'b1;
                push_kind = 1'b0;
            end else if (c == "[") begin
                req_push  = 1'b1;
                push_kind = 1'b1;
            end else if (c == "-") begin
                o_ctl.mode = PM_N_SIGN;
            end else if (c == "0") begin
                o_ctl.mode = PM_N_ZERO;
            end else if (c >= "1" && c <= "9") begin
                o_ctl.mode = PM_N_INT;
            end else if (c == "t") begin
                o_ctl.mode     = PM_LIT_T;
                o_ctl.hex_left = 3'd1;
            end else if (c == "f") begin
                o_ctl.mode     = PM_LIT_F;
                o_ctl.hex_left = 3'd1;
            end else if (c == "n") begin
                o_ctl.mode     = PM_LIT_N;
                o_ctl.hex_left = 3'd1;
            end else begin
                o_ctl.err = 1'b1;
            end
        end

        // The byte following a complete value: separator, closer or whitespace.
        if (req_after && !ws) begin
            if (c == ",") begin
                o_ctl.mode = i_top_kind ? PM_VALUE : PM_OBJ_KEY;
            end else if ((c == "}" && !i_top_kind) || (c == "]" && i_top_kind)) begin
                req_pop = 1'b1;
            end else begin
                o_ctl.err = 1'b1;
            end
        end

        if (req_push) begin
            if (too_deep) begin
                o_ctl.err = 1'b1;
            end else begin
                o_op.push  = 1'b1;
                o_op.kind  = push_kind;
                o_depth    = i_depth + DEPTH_W'(1);
                o_ctl.mode = push_kind ? PM_ARR_FIRST : PM_OBJ_FIRST;
            end
        end

        if (req_pop) begin
            if (i_depth != '0) begin
                o_op.pop = 1'b1;
                o_depth  = i_depth - DEPTH_W'(1);
            end
            o_ctl.mode = (o_depth == '0) ? PM_DONE : PM_AFTER;
        end
    end

endmodule

// ===== hw/rtl/json_syntax_validator.sv =====
// Top level of the streaming JSON syntax validator: byte register, parser state and result register.
//
// Usage: the document enters one byte per transaction on the slave stream
// (i_s_tdata holds the byte, i_s_tlast marks the final byte of the document).
// Bytes that are not marked last produce nothing on the master stream. For the
// byte marked last, one result transaction leaves on the master stream with
// o_m_tdata bit 0 set when the whole document is a well-formed JSON object.
// A zero byte ends the document early; bytes after it up to the last one are
// ignored. After the result the parser returns to its start state on its own,
// so documents can follow back to back.
//
// Flow: a byte is captured in the input register when it is accepted and is
// parsed against the mode, nesting depth and stack top as it leaves that
// register; for the last byte the verdict is then written to the output
// register, which presents the result. The parser takes one byte per cycle in
// every mode while no last byte waits for a full output register; the
// combinational next-state logic on mode, depth and top of stack sets that rate.
// When the receiver stalls, the result waits in the output register and bytes
// keep flowing until a further last byte finds the output register still full;
// that byte then waits in the input register. Reset is synchronous and active
// low; it empties both registers and puts the parser in its start state.
module json_syntax_validator #(
    parameter int MAX_NEST = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_tvalid,
    output logic       o_s_tready,
    input  logic [7:0] i_s_tdata,   // [7:0] byte_in
    input  logic       i_s_tlast,   // last_byte
    output logic       o_m_tvalid,
    input  logic       i_m_tready,
    output logic [7:0] o_m_tdata    // [0] document_valid, [7:1] zero
);
    import jsv_pkg::*;

    localparam int DEPTH_W = $clog2(MAX_NEST + 2);

    // Input register.
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_last;

    // Parser state. The stack is a shift line with the innermost level in bit 0.
    t_ctl               r_ctl;
    logic [DEPTH_W-1:0] r_depth;
    logic [MAX_NEST:0]  r_stack;

    // Result register.
    logic r_out_valid;
    logic r_out_ok;

    t_ctl               n_ctl;
    logic [DEPTH_W-1:0] n_depth;
    t_stack_op          n_op;
    logic               top_kind;
    logic               consume;
    logic               accept;

    // A last byte may only be parsed when the result register can take its verdict.
    assign consume    = r_in_valid && (!r_in_last || !r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || consume;
    assign accept     = i_s_tvalid && o_s_tready;
    assign top_kind   = (r_depth != '0) && r_stack[0];

    jsv_step #(
        .MAX_NEST (MAX_NEST),
        .DEPTH_W  (DEPTH_W)
    ) u_step (
        .i_ctl      (r_ctl),
        .i_depth    (r_depth),
        .i_top_kind (top_kind),
        .i_byte     (r_in_byte),
        .o_ctl      (n_ctl),
        .o_depth    (n_depth),
        .o_op       (n_op)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (accept) begin
            r_in_valid <= 1'b1;
        end else if (consume) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in_byte <= i_s_tdata;
            r_in_last <= i_s_tlast;
        end
    end

    // Parser state update; the last byte of a document returns it to the start state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl   <= '{mode: PM_TOP, hex_left: '0, err: 1'b0, done: 1'b0};
            r_depth <= '0;
        end else if (consume) begin
            if (r_in_last) begin
                r_ctl   <= '{mode: PM_TOP, hex_left: '0, err: 1'b0, done: 1'b0};
                r_depth <= '0;
            end else begin
                r_ctl   <= n_ctl;
                r_depth <= n_depth;
            end
        end
    end

    // Entries above the current depth are never read, so the stack needs no reset.
    always_ff @(posedge i_clk) begin
        if (consume && !r_in_last) begin
            if (n_op.push) begin
                r_stack <= {r_stack[MAX_NEST-1:0], n_op.kind};
            end else if (n_op.pop) begin
                r_stack <= {1'b0, r_stack[MAX_NEST:1]};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (consume && r_in_last) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (consume && r_in_last) begin
            r_out_ok <= !n_ctl.err && (n_ctl.mode == PM_DONE);
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {7'b0, r_out_ok};

endmodule

// ===== hw/rtl/jsv_checker.sv =====
// Port-level checker for the JSON validator and its bind to the top level.
module jsv_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_s_tvalid,
    input logic       o_s_tready,
    input logic [7:0] i_s_tdata,
    input logic       i_s_tlast,
    input logic       o_m_tvalid,
    input logic       i_m_tready,
    input logic [7:0] o_m_tdata
);
    logic in_acc;
    assign in_acc = i_s_tvalid && o_s_tready;

    // A stalled result transaction holds its value.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("result changed while stalled");

    // Reset leaves no result pending and the input side open.
    assert property (@(posedge i_clk) !i_rst_n |=> !o_m_tvalid && o_s_tready)
        else $error("result or stall present after reset");

    // A result needs a last byte: with no byte taken and no result shown, none can appear.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!in_acc && !o_m_tvalid) ##1 (!in_acc && !o_m_tvalid) |=> !o_m_tvalid)
        else $error("result without a last byte");

    // The verdict occupies only bit 0 of the result.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[7:1] == 7'b0))
        else $error("padding bits of the result are not zero");

endmodule

bind json_syntax_validator jsv_checker u_jsv_checker (.*);

// ===== bench/tb.sv =====
// Self-checking stream testbench for the JSON syntax validator, with a byte-level verdict predictor.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import jsv_pkg::*;

    // Nesting limit of the block under test and of the predictor.
    localparam int NEST_LIMIT      = 32;
    // The random part stops once this many bytes and this many documents have gone in.
    localparam int ITEM_TARGET     = 850;
    localparam int MIN_DOCS        = 16;
    // The long receiver hold-off starts after this many documents and lasts this many cycles.
    localparam int HOLD_AFTER_DOCS = 8;
    localparam int HOLD_CYCLES     = 400;
    // The sender pauses until every verdict is back before this random document.
    localparam int PAUSE_AT_DOC    = 10;
    // Idle cycles after the last verdict has arrived, to catch stray results.
    localparam int DRAIN_CYCLES    = 8;
    // Far above the slowest correct run: about ITEM_TARGET bytes with gaps and receiver stalls.
    localparam int CYCLE_LIMIT     = 400000;

    // Predicts the verdict of each document from the accepted bytes and checks the results.
    class verdict_scoreboard #(int NEST = 32);
        logic [MODE_W-1:0] mode;
        bit   [NEST:0]     kinds;       // per open level: 1 = array, 0 = object
        int unsigned       depth;
        logic [HEX_W-1:0]  pos;         // hex digits still due, or next letter of a literal
        bit                err;
        bit                ended;       // a zero byte has closed the document
        bit                verdicts_due[$];
        int unsigned       mismatches;
        int unsigned       results_seen;

        function new();
            mismatches   = 0;
            results_seen = 0;
            clear();
        endfunction

        function void clear();
            mode  = PM_TOP;
            kinds = '0;
            depth = 0;
            pos   = '0;
            err   = 1'b0;
            ended = 1'b0;
        endfunction

        function bit is_blank(logic [7:0] c);
            return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
        endfunction

        function bit is_num(logic [7:0] c);
            return c >= "0" && c <= "9";
        endfunction

        function bit is_hexch(logic [7:0] c);
            return is_num(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
        endfunction

        function bit inner_is_array();
            if (depth == 0 || depth > NEST + 1) return 1'b0;
            return kinds[depth-1];
        endfunction

        function void open_level(bit arr);
            if (depth > NEST) begin
                err = 1'b1;
                return;
            end
            kinds[depth] = arr;
            depth++;
            mode = arr ? PM_ARR_FIRST : PM_OBJ_FIRST;
        endfunction

        function void close_level();
            if (depth > 0) depth--;
            mode = (depth == 0) ? PM_DONE : PM_AFTER;
        endfunction

        function void begin_value(logic [7:0] c);
            if (depth > NEST) err = 1'b1;
            else if (c == "\"") mode = PM_STR;
            else if (c == "{") open_level(1'b0);
            else if (c == "[") open_level(1'b1);
            else if (c == "-") mode = PM_N_SIGN;
            else if (c == "0") mode = PM_N_ZERO;
            else if (c >= "1" && c <= "9") mode = PM_N_INT;
            else if (c == "t") begin
                mode = PM_LIT_T;
                pos  = 3'd1;
            end else if (c == "f") begin
                mode = PM_LIT_F;
                pos  = 3'd1;
            end else if (c == "n") begin
                mode = PM_LIT_N;
                pos  = 3'd1;
            end else err = 1'b1;
        endfunction

        function void follow_value(logic [7:0] c);
            bit arr;
            arr = inner_is_array();
            if (is_blank(c)) return;
            if (c == ",") mode = arr ? PM_VALUE : PM_OBJ_KEY;
            else if ((c == "}" && !arr) || (c == "]" && arr)) close_level();
            else err = 1'b1;
        endfunction

        function void string_char(logic [7:0] c, bit key);
            if (c == "\"") mode = key ? PM_COLON : PM_AFTER;
            else if (c < 8'h20) err = 1'b1;
            else if (c == "\\") mode = key ? PM_KESC : PM_ESC;
        endfunction

        function void escape_char(logic [7:0] c, bit key);
            if (c == "\"" || c == "\\" || c == "/" || c == "b" || c == "f" ||
                c == "n" || c == "r" || c == "t") begin
                mode = key ? PM_KSTR : PM_STR;
            end else if (c == "u") begin
                mode = key ? PM_KHEX : PM_HEX;
                pos  = 3'd4;
            end else begin
                err = 1'b1;
            end
        endfunction

        function void hex_char(logic [7:0] c, bit key);
            if (!is_hexch(c)) begin
                err = 1'b1;
                return;
            end
            pos = pos - 3'd1;
            if (pos == 3'd0) mode = key ? PM_KSTR : PM_STR;
        endfunction

        function void literal_char(logic [7:0] c);
            string word;
            int    len;
            case (mode)
                PM_LIT_T: word = "true";
                PM_LIT_F: word = "false";
                default:  word = "null";
            endcase
            len = word.len();
            if (pos >= len || c != word[pos]) begin
                err = 1'b1;
                return;
            end
            pos = pos + 3'd1;
            if (pos == len) begin
                pos  = 3'd0;
                mode = PM_AFTER;
            end
        endfunction

        // A byte that cannot extend a complete number closes it and is then
        // treated as the byte after a value.
        function void finish_number(logic [7:0] c);
            mode = PM_AFTER;
            follow_value(c);
        endfunction

        function void take(logic [7:0] c);
            case (mode)
                PM_TOP: begin
                    if (!is_blank(c)) begin
                        if (c == "{") open_level(1'b0);
                        else err = 1'b1;
                    end
                end
                PM_OBJ_FIRST: begin
                    if (!is_blank(c)) begin
                        if (c == "}") close_level();
                        else if (c == "\"") mode = PM_KSTR;
                        else err = 1'b1;
                    end
                end
                PM_OBJ_KEY: begin
                    if (!is_blank(c)) begin
                        if (c == "\"") mode = PM_KSTR;
                        else err = 1'b1;
                    end
                end
                PM_COLON: begin
                    if (!is_blank(c)) begin
                        if (c == ":") mode = PM_VALUE;
                        else err = 1'b1;
                    end
                end
                PM_VALUE: begin
                    if (!is_blank(c)) begin_value(c);
                end
                PM_ARR_FIRST: begin
                    if (!is_blank(c)) begin
                        if (c == "]") close_level();
                        else begin_value(c);
                    end
                end
                PM_AFTER: follow_value(c);
                PM_DONE: begin
                    if (!is_blank(c)) err = 1'b1;
                end
                PM_STR:  string_char(c, 1'b0);
                PM_ESC:  escape_char(c, 1'b0);
                PM_HEX:  hex_char(c, 1'b0);
                PM_KSTR: string_char(c, 1'b1);
                PM_KESC: escape_char(c, 1'b1);
                PM_KHEX: hex_char(c, 1'b1);
                PM_N_SIGN: begin
                    if (c == "0") mode = PM_N_ZERO;
                    else if (c >= "1" && c <= "9") mode = PM_N_INT;
                    else err = 1'b1;
                end
                PM_N_ZERO, PM_N_INT: begin
                    if (!(mode == PM_N_INT && is_num(c))) begin
                        if (c == ".") mode = PM_N_DOT;
                        else if (c == "e" || c == "E") mode = PM_N_EXP;
                        else finish_number(c);
                    end
                end
                PM_N_DOT: begin
                    if (is_num(c)) mode = PM_N_FRAC;
                    else err = 1'b1;
                end
                PM_N_FRAC: begin
                    if (!is_num(c)) begin
                        if (c == "e" || c == "E") mode = PM_N_EXP;
                        else finish_number(c);
                    end
                end
                PM_N_EXP: begin
                    if (c == "+" || c == "-") mode = PM_N_ESIGN;
                    else if (is_num(c)) mode = PM_N_EDIG;
                    else err = 1'b1;
                end
                PM_N_ESIGN: begin
                    if (is_num(c)) mode = PM_N_EDIG;
                    else err = 1'b1;
                end
                PM_N_EDIG: begin
                    if (!is_num(c)) finish_number(c);
                end
                PM_LIT_T, PM_LIT_F, PM_LIT_N: literal_char(c);
                default: err = 1'b1;
            endcase
        endfunction

        // Called for every accepted input transaction.
        function void note_byte(logic [7:0] c, logic last);
            if (!ended && !err) begin
                if (c == 8'h00) ended = 1'b1;
                else take(c);
            end
            if (last) begin
                verdicts_due.push_back(!err && mode == PM_DONE);
                clear();
            end
        endfunction

        task report(string what);
            mismatches++;
            $display("MISMATCH at %0t: %s", $realtime, what);
        endtask

        // Called for every accepted result transaction.
        task check_verdict(logic [7:0] data);
            bit want;
            results_seen++;
            if (verdicts_due.size() == 0) begin
                report($sformatf("result %0d arrived with no document pending", results_seen));
                return;
            end
            want = verdicts_due.pop_front();
            if (data[0] !== want)
                report($sformatf("result %0d: document_valid %b, predicted %b",
                                 results_seen, data[0], want));
            if (data[7:1] !== 7'd0)
                report($sformatf("result %0d: padding bits %b, expected zero",
                                 results_seen, data[7:1]));
        endtask
    endclass

    logic       i_clk      = 1'b0;
    logic       i_rst_n    = 1'b0;
    logic       i_s_tvalid = 1'b0;
    logic       o_s_tready;
    logic [7:0] i_s_tdata  = 8'h00;
    logic       i_s_tlast  = 1'b0;
    logic       o_m_tvalid;
    logic       i_m_tready = 1'b0;
    logic [7:0] o_m_tdata;

    verdict_scoreboard #(NEST_LIMIT) sb;

    // Bytes of the document that is about to be sent.
    logic [7:0] doc_q[$];
    int         burst_left = 0;
    int         bytes_sent = 0;
    int         docs_sent  = 0;
    bit         hold_off   = 1'b0;
    int         rx_style   = 0;
    int         rx_left    = 0;
    int         cycles     = 0;
    string      esc_letters = "\"\\/bfnrt";
    string      hex_letters = "0123456789abcdefABCDEF";

    json_syntax_validator #(
        .MAX_NEST(NEST_LIMIT)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // The run is cut off if it takes far longer than any correct run could.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("json_syntax_validator verification failed");
            $finish;
        end
    end

    // Result side. Every result transaction is checked against the oldest
    // prediction. The ready pattern switches between always ready, coin-flip,
    // mostly stalled and toggling, each for a random stretch; the hold-off
    // flag overrides it and keeps the output stalled.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_m_tvalid && i_m_tready) sb.check_verdict(o_m_tdata);
            if (rx_left == 0) begin
                rx_style = $urandom_range(0, 3);
                rx_left  = $urandom_range(10, 60);
            end else begin
                rx_left--;
            end
            case (rx_style)
                0:       i_m_tready <= !hold_off;
                1:       i_m_tready <= !hold_off && ($urandom_range(0, 1) == 1);
                2:       i_m_tready <= !hold_off && ($urandom_range(0, 5) == 0);
                default: i_m_tready <= !hold_off && !i_m_tready;
            endcase
        end
    end

    // Long stall of the receiver while the sender keeps going. The result
    // register fills first, then the next last byte parks in the input
    // register and the block holds its input ready low.
    initial begin
        wait (docs_sent >= HOLD_AFTER_DOCS);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_off <= 1'b0;
    end

    function automatic void put(logic [7:0] b);
        doc_q.push_back(b);
    endfunction

    function automatic void load_text(string s);
        for (int i = 0; i < s.len(); i++) put(s[i]);
    endfunction

    // Zero to two whitespace bytes, vertical tab and form feed included.
    function automatic void put_ws();
        int n;
        n = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 2) : 0;
        repeat (n) begin
            case ($urandom_range(0, 5))
                0:       put(8'h20);
                1:       put(8'h09);
                2:       put(8'h0A);
                3:       put(8'h0B);
                4:       put(8'h0C);
                default: put(8'h0D);
            endcase
        end
    endfunction

    // A string with printable bytes, raw high bytes, simple escapes and \u escapes.
    function automatic void put_string();
        logic [7:0] c;
        put("\"");
        repeat ($urandom_range(0, 5)) begin
            case ($urandom_range(0, 5))
                0, 1, 2: begin
                    c = 8'($urandom_range(8'h20, 8'h7E));
                    if (c == "\"" || c == "\\") c = "a";
                    put(c);
                end
                3: put(8'($urandom_range(8'h80, 8'hFF)));
                4: begin
                    put("\\");
                    put(esc_letters[$urandom_range(0, esc_letters.len() - 1)]);
                end
                default: begin
                    put("\\");
                    put("u");
                    repeat (4) put(hex_letters[$urandom_range(0, hex_letters.len() - 1)]);
                end
            endcase
        end
        put("\"");
    endfunction

    function automatic void put_number();
        if ($urandom_range(0, 2) == 0) put("-");
        if ($urandom_range(0, 3) == 0) begin
            put("0");
        end else begin
            put(8'($urandom_range("1", "9")));
            repeat ($urandom_range(0, 3)) put(8'($urandom_range("0", "9")));
        end
        if ($urandom_range(0, 1) == 1) begin
            put(".");
            repeat ($urandom_range(1, 3)) put(8'($urandom_range("0", "9")));
        end
        if ($urandom_range(0, 2) == 0) begin
            put($urandom_range(0, 1) ? "e" : "E");
            case ($urandom_range(0, 2))
                0: put("+");
                1: put("-");
                default: ;
            endcase
            repeat ($urandom_range(1, 2)) put(8'($urandom_range("0", "9")));
        end
    endfunction

    function automatic void put_literal();
        case ($urandom_range(0, 2))
            0:       load_text("true");
            1:       load_text("false");
            default: load_text("null");
        endcase
    endfunction

    function automatic void put_scalar();
        case ($urandom_range(0, 2))
            0:       put_string();
            1:       put_number();
            default: put_literal();
        endcase
    endfunction

    // A well-formed object of random shape, built level by level without recursion.
    function automatic void build_tree(int max_depth, int max_members);
        bit arr[0:15];
        int cnt[0:15];
        int lvl;
        int r;
        doc_q.delete();
        put_ws();
        put("{");
        arr[0] = 1'b0;
        cnt[0] = 0;
        lvl    = 1;
        while (lvl > 0) begin
            put_ws();
            if (cnt[lvl-1] >= max_members || $urandom_range(0, 3) == 0) begin
                put(arr[lvl-1] ? "]" : "}");
                lvl--;
            end else begin
                if (cnt[lvl-1] > 0) begin
                    put(",");
                    put_ws();
                end
                cnt[lvl-1]++;
                if (!arr[lvl-1]) begin
                    put_string();
                    put_ws();
                    put(":");
                    put_ws();
                end
                r = $urandom_range(0, 9);
                if (r < 3 && lvl < max_depth) begin
                    arr[lvl] = 1'($urandom_range(0, 1));
                    cnt[lvl] = 0;
                    put(arr[lvl] ? "[" : "{");
                    lvl++;
                end else begin
                    put_scalar();
                end
            end
        end
        put_ws();
    endfunction

    // A single chain of containers around the nesting limit, with an empty
    // innermost level or one scalar inside it.
    function automatic void build_deep(int levels, bit scalar_inside);
        bit arr[0:63];
        int k;
        doc_q.delete();
        put("{");
        arr[0] = 1'b0;
        for (k = 1; k < levels; k++) begin
            if (!arr[k-1]) load_text("\"k\":");
            arr[k] = 1'($urandom_range(0, 1));
            put(arr[k] ? "[" : "{");
        end
        if (scalar_inside) begin
            if (!arr[levels-1]) load_text("\"k\":");
            put_number();
        end
        for (k = levels - 1; k >= 0; k--) put(arr[k] ? "]" : "}");
    endfunction

    // One random flaw: a changed byte, an extra byte, a cut, an early zero
    // byte or trailing junk.
    function automatic void damage_doc();
        int at;
        at = $urandom_range(0, doc_q.size() - 1);
        case ($urandom_range(0, 4))
            0: doc_q[at] = 8'($urandom_range(0, 255));
            1: doc_q.insert(at, 8'($urandom_range(0, 255)));
            2: while (doc_q.size() > at + 1) void'(doc_q.pop_back());
            3: doc_q.insert(at, 8'h00);
            default: put(8'($urandom_range(0, 255)));
        endcase
    endfunction

    // Sends one byte as an input transaction. Between bursts of random length
    // the valid line drops for a random gap; a burst of zero gap keeps valid
    // high across the boundary.
    task automatic send_byte(input logic [7:0] b, input logic last);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                i_s_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 90)
                                                      : $urandom_range(1, 12);
        end
        burst_left--;
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= b;
        i_s_tlast  <= last;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        sb.note_byte(b, last);
        bytes_sent++;
    endtask

    // Sends the prepared document with last set on its final byte.
    task automatic send_doc();
        for (int i = 0; i < doc_q.size(); i++) send_byte(doc_q[i], i == doc_q.size() - 1);
        docs_sent++;
    endtask

    initial begin
        int r;
        int k;
        sb = new();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed documents. The smallest valid object.
        doc_q.delete();
        load_text("{}");
        send_doc();
        // Vertical tab and form feed count as whitespace on both sides.
        doc_q.delete();
        put(8'h0B);
        load_text("{}");
        put(8'h0C);
        send_doc();
        // A zero byte ends the document, so the 0xFF after it is ignored.
        doc_q.delete();
        load_text("{}");
        put(8'h00);
        put(8'hFF);
        send_doc();
        // The top value must be an object.
        doc_q.delete();
        load_text("[");
        send_doc();
        // A control byte inside a key is rejected, and the rest is ignored.
        doc_q.delete();
        load_text("{\"");
        put(8'h01);
        load_text("\"}");
        send_doc();
        // An escape letter outside the allowed set.
        doc_q.delete();
        load_text("{\"\\q\"}");
        send_doc();

        // Random documents: mostly well-formed objects with random content,
        // some damaged, some deep chains around the nesting limit, some with a
        // non-object top value and some pure noise.
        for (k = 0; bytes_sent < ITEM_TARGET || k < MIN_DOCS; k++) begin
            if (k == PAUSE_AT_DOC) begin
                // Let the block drain completely before going on.
                i_s_tvalid <= 1'b0;
                @(posedge i_clk);
                while (sb.verdicts_due.size() != 0) @(posedge i_clk);
                burst_left = 0;
            end
            r = $urandom_range(0, 99);
            if (k == 2) begin
                build_deep(NEST_LIMIT + 1, 1'b1);
            end else if (k == 5) begin
                build_deep(NEST_LIMIT + 1, 1'b0);
            end else if (r < 6) begin
                build_deep($urandom_range(NEST_LIMIT - 2, NEST_LIMIT + 2),
                           1'($urandom_range(0, 1)));
            end else if (r < 14) begin
                doc_q.delete();
                repeat ($urandom_range(1, 12)) put(8'($urandom_range(0, 255)));
            end else if (r < 20) begin
                doc_q.delete();
                put_ws();
                if ($urandom_range(0, 3) == 0) load_text("[]");
                else put_scalar();
                put_ws();
            end else begin
                build_tree($urandom_range(1, 5), $urandom_range(1, 4));
                if (r >= 70) damage_doc();
            end
            send_doc();
        end

        i_s_tvalid <= 1'b0;
        while (sb.verdicts_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.mismatches == 0) begin
            $display("json_syntax_validator verification clean");
        end else begin
            $display("json_syntax_validator verification failed");
        end
        $finish;
    end

endmodule
